>>> rtl/sdtq_pkg.sv
// Package for the sorted deadline timeout queue: word types, status codes,
// opcodes and sizing constants. No dependencies.
package sdtq_pkg;

   localparam int SlotsDefault = 16;
   localparam int SlotW = 4;
   localparam int MaxResults = 16;
   localparam logic [9:0] UsPerMs = 10'd1000;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_CANCEL = 2'd1,
      OP_TICK   = 2'd2,
      OP_QUERY  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_STARTED   = 3'd0,
      ST_ACTIVE    = 3'd1,
      ST_REJECTED  = 3'd2,
      ST_CANCELLED = 3'd3,
      ST_INACTIVE  = 3'd4,
      ST_EXPIRED   = 3'd5,
      ST_NONE      = 3'd6,
      ST_QUERY     = 3'd7
   } status_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  slot;
      logic        is_absolute;
      logic [31:0] span_ms;
      logic [63:0] due_us;
      logic [63:0] now_us;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  slot_out;
      logic [63:0] time_us;
      logic        is_active;
      logic        has_expired;
      logic [4:0]  active_count;
      logic        last;
   } rsp_type;

endpackage

>>> rtl/sorted_deadline_timeout_queue_top.sv
// Sorted deadline timeout queue, top level with sequencer and storage.
// Depends on sdtq_pkg.
//
// One word is taken at a time; req_stall stays high from the accepting edge
// until the last result of that word has been loaded into the output
// register, and the next word can be taken in the following cycle. A shared
// 64-bit subtract/compare unit serves the expiry compares and all
// elapsed/remaining times. A start walks the order list back from the
// tail and moves every entry that expires later up one place; a cancel
// compacts the list; a tick takes due entries from the head, at most
// MaxResults, and compacts the list after each. An output stall holds
// the sequencer in S_OUT until the output register is free. Slot times
// and the order list are small memories read one address per cycle,
// registered.
module sorted_deadline_timeout_queue_top
   import sdtq_pkg::*;
#(
   parameter int SLOTS = SlotsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic [31:0] csr_data
);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int PW = $clog2(SLOTS);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_READ, S_MUL, S_SUM, S_INS_RD, S_INS_SLOT, S_INS_CMP,
      S_INS_DONE, S_RM_STEP, S_T_HEAD, S_T_CMP, S_T_ELAP, S_T_FIN, S_OUT
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   // Configuration register
   logic [31:0] maxdur_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         maxdur_ff <= 32'hFFFF_FFFF;
      end else if (csr_valid && csr_ready) begin
         maxdur_ff <= csr_data;
      end
   end
   assign csr_ready = 1'b1;

   // Slot flags and memories
   logic [SLOTS-1:0] act_ff, exp_ff, act_in, exp_in;
   logic [63:0] start_mem [SLOTS];
   logic [63:0] expiry_mem [SLOTS];
   logic [PW-1:0] order_mem [SLOTS];
   logic [CW-1:0] count_ff, count_in;

   req_type       req_ff, req_in;
   rsp_type       res_ff, res_in;      // result under construction
   rsp_type       rsp_ff, rsp_in;      // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [41:0]   prod_ff, prod_in;
   logic [63:0]   newexp_ff, newexp_in;
   logic [PW-1:0] cur_ff, cur_in;      // slot being worked on
   logic [PW-1:0] mv_ff, mv_in;        // order entry being moved up
   logic [CW-1:0] pos_ff, pos_in;      // walk index
   logic [CW-1:0] wr_ff, wr_in;        // compaction write index
   logic [4:0]    emitted_ff, emitted_in;
   logic          held_ff, held_in;    // tick has an expiry result waiting
   logic          tick_ff, tick_in;
   logic [63:0]   st_rd_ff, ex_rd_ff;
   logic [PW-1:0] ord_rd_ff;

   logic slot_ok;
   assign slot_ok = (32'(req_ff.slot) < 32'(SLOTS));

   // Shared unit: one 64-bit subtract with borrow (borrow means ua < ub)
   logic [63:0] ua, ub, udiff;
   logic        uborrow;
   always_comb begin
      {uborrow, udiff} = {1'b0, ua} - {1'b0, ub};
   end

   // Memory write/read controls
   logic          ord_we, slot_we;
   logic [PW-1:0] ord_wa, ord_wd;
   logic [PW-1:0] rd_slot, rd_ord;

   always_ff @(posedge clock) begin
      if (ord_we) begin
         order_mem[ord_wa] <= ord_wd;
      end
      ord_rd_ff <= order_mem[rd_ord];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         start_mem[cur_ff]  <= req_ff.now_us;
         expiry_mem[cur_ff] <= newexp_ff;
      end
      st_rd_ff <= start_mem[rd_slot];
      ex_rd_ff <= expiry_mem[rd_slot];
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Sequencer combinational part
   always_comb begin
      state_in = state_ff; ret_in = ret_ff; req_in = req_ff; res_in = res_ff;
      rsp_in = rsp_ff; rsp_valid_in = rsp_valid_ff; prod_in = prod_ff;
      newexp_in = newexp_ff; cur_in = cur_ff; mv_in = mv_ff; pos_in = pos_ff;
      wr_in = wr_ff; emitted_in = emitted_ff; held_in = held_ff;
      tick_in = tick_ff; act_in = act_ff; exp_in = exp_ff; count_in = count_ff;
      ord_we = 1'b0; ord_wa = '0; ord_wd = '0; slot_we = 1'b0;
      rd_slot = cur_ff; rd_ord = '0;
      ua = '0; ub = '0;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               cur_in = PW'(req_data.slot);
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            // slot times of the addressed slot are read for the next cycle
            res_in = '0;
            res_in.slot_out = req_ff.slot;
            res_in.last = 1'b1;
            res_in.active_count = 5'(count_ff);
            ret_in = S_IDLE;
            unique case (op_type'(req_ff.op))
               OP_START: begin
                  if (slot_ok && act_ff[cur_ff]) begin
                     res_in.status = ST_ACTIVE;
                     res_in.is_active = 1'b1;
                     res_in.has_expired = exp_ff[cur_ff];
                     state_in = S_READ;
                  end else if (!slot_ok || req_ff.span_ms > maxdur_ff) begin
                     res_in.status = ST_REJECTED;
                     res_in.has_expired = slot_ok && exp_ff[cur_ff];
                     state_in = S_OUT;
                  end else begin
                     state_in = S_MUL;
                  end
               end
               OP_CANCEL: begin
                  if (!slot_ok || !act_ff[cur_ff]) begin
                     res_in.status = ST_INACTIVE;
                     res_in.has_expired = slot_ok && exp_ff[cur_ff];
                     state_in = S_OUT;
                  end else begin
                     res_in.status = ST_CANCELLED;
                     res_in.has_expired = exp_ff[cur_ff];
                     tick_in = 1'b0;
                     state_in = S_READ;
                  end
               end
               OP_TICK: begin
                  emitted_in = '0;
                  held_in = 1'b0;
                  tick_in = 1'b1;
                  state_in = S_T_HEAD;
               end
               OP_QUERY: begin
                  res_in.status = ST_QUERY;
                  if (slot_ok) begin
                     res_in.is_active = act_ff[cur_ff];
                     res_in.has_expired = exp_ff[cur_ff];
                     state_in = S_READ;
                  end else begin
                     state_in = S_OUT;
                  end
               end
            endcase
         end
         S_READ: begin
            // st_rd_ff / ex_rd_ff hold the addressed slot
            unique case (op_type'(req_ff.op))
               OP_START: begin
                  res_in.time_us = ex_rd_ff;
                  state_in = S_OUT;
               end
               OP_CANCEL: begin
                  ua = req_ff.now_us; ub = st_rd_ff;
                  res_in.time_us = udiff;
                  act_in[cur_ff] = 1'b0;
                  pos_in = '0; wr_in = '0;
                  state_in = S_RM_STEP;
               end
               default: begin
                  // remaining time, zero when inactive or overdue
                  ua = ex_rd_ff; ub = req_ff.now_us;
                  res_in.time_us = (act_ff[cur_ff] && !uborrow) ? udiff : 64'd0;
                  state_in = S_OUT;
               end
            endcase
         end
         S_MUL: begin
            prod_in = 42'(req_ff.span_ms) * 42'(UsPerMs);
            state_in = S_SUM;
         end
         S_SUM: begin
            newexp_in = req_ff.is_absolute ? req_ff.due_us :
               req_ff.now_us + 64'(prod_ff);
            pos_in = count_ff;
            state_in = S_INS_RD;
         end
         S_INS_RD: begin
            // walk back from the tail: read order entry pos-1
            if (pos_ff == '0) begin
               state_in = S_INS_DONE;
            end else begin
               rd_ord = PW'(pos_ff - CW'(1));
               state_in = S_INS_SLOT;
            end
         end
         S_INS_SLOT: begin
            mv_in = ord_rd_ff;
            rd_slot = ord_rd_ff;
            state_in = S_INS_CMP;
         end
         S_INS_CMP: begin
            // a later expiry moves up one place, an equal or earlier one stops
            ua = newexp_ff; ub = ex_rd_ff;
            if (uborrow) begin
               ord_we = 1'b1;
               ord_wa = PW'(pos_ff);
               ord_wd = mv_ff;
               pos_in = pos_ff - CW'(1);
               state_in = S_INS_RD;
            end else begin
               state_in = S_INS_DONE;
            end
         end
         S_INS_DONE: begin
            ord_we = 1'b1;
            ord_wa = PW'(pos_ff);
            ord_wd = cur_ff;
            slot_we = 1'b1;
            count_in = count_ff + CW'(1);
            act_in[cur_ff] = 1'b1;
            exp_in[cur_ff] = 1'b0;
            res_in.status = ST_STARTED;
            res_in.time_us = newexp_ff;
            res_in.is_active = 1'b1;
            res_in.has_expired = 1'b0;
            res_in.active_count = 5'(count_ff + CW'(1));
            state_in = S_OUT;
         end
         S_RM_STEP: begin
            // compact order list, dropping cur_ff; one entry per cycle
            if (pos_ff < count_ff) begin
               rd_ord = PW'(pos_ff + CW'(1));
               if (ord_rd_ff != cur_ff) begin
                  ord_we = 1'b1;
                  ord_wa = PW'(wr_ff);
                  ord_wd = ord_rd_ff;
                  wr_in = wr_ff + CW'(1);
               end
               pos_in = pos_ff + CW'(1);
            end else begin
               count_in = wr_ff;
               res_in.active_count = 5'(wr_ff);
               if (tick_ff) begin
                  emitted_in = emitted_ff + 5'd1;
                  held_in = 1'b1;
                  state_in = S_T_HEAD;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_T_HEAD: begin
            // ord_rd_ff holds the list head
            if (count_ff == '0 || emitted_ff == 5'(MaxResults)) begin
               state_in = S_T_FIN;
            end else begin
               cur_in = ord_rd_ff;
               rd_slot = ord_rd_ff;
               state_in = S_T_CMP;
            end
         end
         S_T_CMP: begin
            ua = req_ff.now_us; ub = ex_rd_ff;
            if (uborrow) begin
               state_in = S_T_FIN;
            end else if (held_ff) begin
               // another one is due, so the waiting result is not the last
               ret_in = S_T_ELAP;
               state_in = S_OUT;
            end else begin
               state_in = S_T_ELAP;
            end
         end
         S_T_ELAP: begin
            ua = req_ff.now_us; ub = st_rd_ff;
            res_in = '0;
            res_in.status = ST_EXPIRED;
            res_in.slot_out = 4'(cur_ff);
            res_in.time_us = udiff;
            res_in.has_expired = 1'b1;
            act_in[cur_ff] = 1'b0;
            exp_in[cur_ff] = 1'b1;
            pos_in = '0; wr_in = '0;
            state_in = S_RM_STEP;
         end
         S_T_FIN: begin
            ret_in = S_IDLE;
            if (held_ff) begin
               res_in.last = 1'b1;
            end else begin
               res_in = '0;
               res_in.status = ST_NONE;
               res_in.last = 1'b1;
               res_in.active_count = 5'(count_ff);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ret_ff <= S_IDLE;
         act_ff <= '0; exp_ff <= '0; count_ff <= '0;
         rsp_valid_ff <= 1'b0; emitted_ff <= '0;
         pos_ff <= '0; wr_ff <= '0; tick_ff <= 1'b0; held_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ret_ff <= ret_in;
         act_ff <= act_in; exp_ff <= exp_in; count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in; emitted_ff <= emitted_in;
         pos_ff <= pos_in; wr_ff <= wr_in; tick_ff <= tick_in; held_ff <= held_in;
      end
      req_ff <= req_in; res_ff <= res_in; rsp_ff <= rsp_in;
      prod_ff <= prod_in; newexp_ff <= newexp_in;
      cur_ff <= cur_in; mv_ff <= mv_in;
   end
endmodule
